/* hdl/b2ss_pkg.sv */
// ----------------------------------------------------------------------------
// b2ss_pkg
// Widths, decimal weights and segment codes for the binary to seven-segment
// digit writer.
// ----------------------------------------------------------------------------
package b2ss_pkg;

    localparam int VALUE_W = 27;
    localparam int POS_W   = 4;
    localparam int SEG_W   = 8;
    localparam int DIGIT_W = 4;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [SEG_W-1:0]   seg_t;

    function automatic int pow10(input int e);
        int p;
        p = 1;
        for (int i = 0; i < e; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic value_t digit_weight(input int m, input int k);
        return VALUE_W'(m * pow10(k));
    endfunction

    function automatic seg_t seg_code(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 8'h7e;
            4'd1:    s = 8'h30;
            4'd2:    s = 8'h6d;
            4'd3:    s = 8'h79;
            4'd4:    s = 8'h33;
            4'd5:    s = 8'h5b;
            4'd6:    s = 8'h5f;
            4'd7:    s = 8'h70;
            4'd8:    s = 8'h7f;
            default: s = 8'h7b;
        endcase
        return s;
    endfunction

endpackage

/* hdl/binary_to_seven_segment_digits_unit.sv */
// ----------------------------------------------------------------------------
// binary_to_seven_segment_digits_unit
// Saturates a binary value, peels off one decimal digit per pipeline stage
// and writes the digits out as seven-segment words, most significant first.
// ----------------------------------------------------------------------------
// The first word passes the entry register, the digit stages and the output
//   register; the remaining words follow on consecutive cycles.
// A new value can be taken before the last one has left the stages; the single
//   output port carrying NUM_DIGITS words sets the spacing, and busy holds off start.
// No back-pressure: every word is taken in the cycle it is strobed.
// Reset clears the stage valid bits, the output strobe and the busy counter.
module binary_to_seven_segment_digits_unit #(
    parameter int NUM_DIGITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [b2ss_pkg::VALUE_W-1:0]  value,
    output logic                          strobe,
    output logic [b2ss_pkg::POS_W-1:0]    digit_position,
    output logic [b2ss_pkg::SEG_W-1:0]    segment_code,
    output logic                          last
);

    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam b2ss_pkg::value_t SAT_MAX =
        b2ss_pkg::VALUE_W'(b2ss_pkg::pow10(NUM_DIGITS) - 1);

    logic                    accept;
    logic [CNT_W-1:0]        gap_reg;
    logic [CNT_W-1:0]        gap_next;

    logic                    vld_reg [0:NUM_DIGITS];
    b2ss_pkg::value_t        rem_reg [0:NUM_DIGITS];
    logic [BCD_W-1:0]        bcd_reg [0:NUM_DIGITS];

    logic [BCD_W-1:0]              ser_bcd_reg;
    logic [b2ss_pkg::POS_W-1:0]    ser_left_reg;
    logic                          strobe_reg;
    logic [b2ss_pkg::POS_W-1:0]    pos_reg;
    logic [b2ss_pkg::SEG_W-1:0]    seg_reg;
    logic                          last_reg;

    assign accept = start && !busy;
    assign busy   = (gap_reg != '0);

    always_comb
    begin
        gap_next = gap_reg;
        if (accept) begin
            gap_next = CNT_W'(NUM_DIGITS - 1);
        end else if (gap_reg != '0) begin
            gap_next = gap_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gap_reg <= '0;
        end else begin
            gap_reg <= gap_next;
        end
    end

    // saturate on entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end else begin
            vld_reg[0] <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            rem_reg[0] <= (value > SAT_MAX) ? SAT_MAX : value;
            bcd_reg[0] <= '0;
        end
    end

    // one digit per stage, most significant first
    for (genvar j = 1; j <= NUM_DIGITS; j++) begin : g_stage
        localparam int K = NUM_DIGITS - j;

        b2ss_pkg::digit_t  dig_next;
        b2ss_pkg::value_t  sub_next;
        b2ss_pkg::value_t  rem_next;
        logic [BCD_W-1:0]  bcd_next;

        always_comb
        begin
            dig_next = '0;
            sub_next = '0;
            for (int m = 1; m <= 9; m++) begin
                if (rem_reg[j-1] >= b2ss_pkg::digit_weight(m, K)) begin
                    dig_next = b2ss_pkg::DIGIT_W'(m);
                    sub_next = b2ss_pkg::digit_weight(m, K);
                end
            end
            rem_next = rem_reg[j-1] - sub_next;
            bcd_next = bcd_reg[j-1];
            bcd_next[4*K +: 4] = dig_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[j] <= 1'b0;
            end else begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (vld_reg[j-1]) begin
                rem_reg[j] <= rem_next;
                bcd_reg[j] <= bcd_next;
            end
        end
    end

    // serialise the digits, one word per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            strobe_reg   <= 1'b0;
            ser_left_reg <= '0;
        end else if (vld_reg[NUM_DIGITS]) begin
            strobe_reg   <= 1'b1;
            ser_left_reg <= b2ss_pkg::POS_W'(NUM_DIGITS - 1);
        end else if (ser_left_reg != '0) begin
            strobe_reg   <= 1'b1;
            ser_left_reg <= ser_left_reg - 1'b1;
        end else begin
            strobe_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[NUM_DIGITS]) begin
            ser_bcd_reg <= bcd_reg[NUM_DIGITS] << 4;
            pos_reg     <= b2ss_pkg::POS_W'(NUM_DIGITS);
            seg_reg     <= b2ss_pkg::seg_code(bcd_reg[NUM_DIGITS][BCD_W-1 -: 4]);
            last_reg    <= (NUM_DIGITS == 1);
        end else if (ser_left_reg != '0) begin
            ser_bcd_reg <= ser_bcd_reg << 4;
            pos_reg     <= ser_left_reg;
            seg_reg     <= b2ss_pkg::seg_code(ser_bcd_reg[BCD_W-1 -: 4]);
            last_reg    <= (ser_left_reg == b2ss_pkg::POS_W'(1));
        end
    end

    assign strobe         = strobe_reg;
    assign digit_position = pos_reg;
    assign segment_code   = seg_reg;
    assign last           = last_reg;

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> digit_position == b2ss_pkg::POS_W'(1))
        else $error("last word not at position one");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && digit_position == $past(digit_position) - 1'b1)
        else $error("word run broken");

    a_seg_top: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> segment_code[b2ss_pkg::SEG_W-1] == 1'b0)
        else $error("unused segment bit set");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy == (NUM_DIGITS > 1))
        else $error("busy not raised after take");

endmodule
